>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition on the left implies condition on the right in the same cycle
`define UPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
// condition on the left implies condition on the right in the next cycle
`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define UPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/upd_pkg.sv
// types, constants and helpers of the url percent decoder
package upd_pkg;

	localparam int MAX_STRING_LEN_DEF = 4096;
	localparam int LEN_W = 13;
	localparam int LEN_FIELD_MAX = 8191;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		MODE_NORMAL  = 4'b0001,
		MODE_PCT     = 4'b0010,
		MODE_DIGIT   = 4'b0100,
		MODE_DISCARD = 4'b1000
	} mode_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        data;
		logic [LEN_W-1:0]  length;
		logic              last;
	} result_t;

	// up to three results caused by one input byte, res[0] goes out first
	typedef struct packed {
		logic [1:0]    n;
		result_t [2:0] res;
	} group_t;

	function automatic logic hex_ok(input logic [7:0] b);
		return ((b >= 8'h30) && (b <= 8'h39)) ||
		       ((b >= 8'h61) && (b <= 8'h66)) ||
		       ((b >= 8'h41) && (b <= 8'h46));
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] b);
		logic [7:0] v;
		v = 8'h00;
		if ((b >= 8'h30) && (b <= 8'h39)) begin
			v = b - 8'h30;
		end else if ((b >= 8'h61) && (b <= 8'h66)) begin
			v = b - 8'h57;
		end else if ((b >= 8'h41) && (b <= 8'h46)) begin
			v = b - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] plus_to_space(input logic [7:0] b);
		return (b == CHAR_PLUS) ? CHAR_SPACE : b;
	endfunction

	function automatic result_t data_res(input logic [7:0] b);
		result_t r;
		r.kind   = KIND_DATA;
		r.data   = b;
		r.length = '0;
		r.last   = 1'b0;
		return r;
	endfunction

	function automatic result_t done_res(input logic [LEN_W-1:0] len);
		result_t r;
		r.kind   = KIND_DONE;
		r.data   = 8'h00;
		r.length = len;
		r.last   = 1'b1;
		return r;
	endfunction

	function automatic result_t err_res();
		result_t r;
		r.kind   = KIND_ERROR;
		r.data   = 8'h00;
		r.length = '0;
		r.last   = 1'b1;
		return r;
	endfunction

endpackage

>>> rtl/core/upd_decode.sv
// decode state and the per-byte result logic
module upd_decode
	import upd_pkg::*;
#(
	parameter int MAX_STRING_LEN = MAX_STRING_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] byte_s1,
	input  logic       last_s1,
	output group_t     grp
);

	localparam logic [LEN_W-1:0] LenCap =
		LEN_W'((MAX_STRING_LEN < LEN_FIELD_MAX) ? MAX_STRING_LEN : LEN_FIELD_MAX);

	mode_t            mode_q, mode_d;
	logic [7:0]       held_q, held_d;
	logic [LEN_W-1:0] count_q, count_d;
	logic [LEN_W-1:0] cnt1, cnt2;
	logic             digits_ok;

	always_comb begin
		cnt1      = (count_q < LenCap) ? count_q + LEN_W'(1) : count_q;
		cnt2      = (cnt1 < LenCap) ? cnt1 + LEN_W'(1) : cnt1;
		digits_ok = hex_ok(held_q) && hex_ok(byte_s1);
		mode_d    = mode_q;
		held_d    = held_q;
		count_d   = count_q;
		grp       = '0;
		case (mode_q)
			MODE_NORMAL: begin
				if ((byte_s1 == CHAR_PCT) && !last_s1) begin
					mode_d = MODE_PCT;
				end else begin
					grp.res[0] = data_res(plus_to_space(byte_s1));
					grp.n      = 2'd1;
					count_d    = cnt1;
					if (last_s1) begin
						grp.res[1] = done_res(cnt1);
						grp.n      = 2'd2;
						count_d    = '0;
						held_d     = 8'h00;
					end
				end
			end
			MODE_PCT: begin
				if (last_s1) begin
					// string ends right after the percent: pass both through
					grp.res[0] = data_res(CHAR_PCT);
					grp.res[1] = data_res(plus_to_space(byte_s1));
					grp.res[2] = done_res(cnt2);
					grp.n      = 2'd3;
					count_d    = '0;
					held_d     = 8'h00;
					mode_d     = MODE_NORMAL;
				end else begin
					held_d = byte_s1;
					mode_d = MODE_DIGIT;
				end
			end
			MODE_DIGIT: begin
				held_d = 8'h00;
				if (!digits_ok) begin
					grp.res[0] = err_res();
					grp.n      = 2'd1;
					count_d    = '0;
					mode_d     = last_s1 ? MODE_NORMAL : MODE_DISCARD;
				end else begin
					grp.res[0] = data_res({hex_val(held_q), hex_val(byte_s1)});
					grp.n      = 2'd1;
					count_d    = cnt1;
					mode_d     = MODE_NORMAL;
					if (last_s1) begin
						grp.res[1] = done_res(cnt1);
						grp.n      = 2'd2;
						count_d    = '0;
					end
				end
			end
			MODE_DISCARD: begin
				if (last_s1) begin
					mode_d  = MODE_NORMAL;
					count_d = '0;
					held_d  = 8'h00;
				end
			end
			default: begin
				mode_d  = MODE_NORMAL;
				count_d = '0;
				held_d  = 8'h00;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			held_q  <= 8'h00;
			count_q <= '0;
		end else if (adv) begin
			mode_q  <= mode_d;
			held_q  <= held_d;
			count_q <= count_d;
		end
	end

endmodule

>>> rtl/core/upd_result_buf.sv
// result register that holds one group and hands it out one result a cycle while take is high
module upd_result_buf
	import upd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  group_t  grp,
	input  logic    take,
	output logic    valid,
	output logic    free,
	output result_t head
);

	logic [1:0]    cnt_q;
	result_t [2:0] res_q;

	assign valid = (cnt_q != 2'd0);
	assign head  = res_q[0];
	// empty now, or the last result leaves this cycle
	assign free  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= grp.n;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= grp.res;
		end else if (take) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

>>> rtl/core/url_percent_decoder_core.sv
// url percent decoder top level
//
// input channel: one encoded byte per transaction on in_byte, in_last set on
// the final byte of a string. output channel: one result per transaction,
// out_kind data, done (with out_length) or bad-hex error, out_last on the
// final result of a string. both channels use valid/stall; a transaction
// happens on a clock edge with valid high and stall low.
// a byte is registered at acceptance and decoded from the input register into a
// group of zero to three results, loaded into the result register once that is
// free; a stalled receiver can keep a byte waiting in the input register.
// a byte that causes at most one result is taken every cycle while the receiver
// does not stall; a byte that causes n results keeps the output busy until all n
// have left, and the result register limits the rate to one result per cycle.
// bytes that are only held (percent and first digit) give no result.
// when the receiver stalls, the result register holds and the input stalls
// once its input register is full and the result register cannot drain.
// asynchronous reset clears the decode state, the held byte and the count.
`include "assert_macros.svh"
module url_percent_decoder_core
	import upd_pkg::*;
#(
	parameter int MAX_STRING_LEN = MAX_STRING_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       out_kind,
	output logic [7:0]       out_byte,
	output logic [LEN_W-1:0] out_length,
	output logic             out_last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;
	logic       accept;
	logic       buf_free;
	logic       take;
	group_t     grp;
	result_t    head;

	assign take     = out_valid && !out_stall;
	assign adv      = valid_s1 && buf_free;
	assign in_stall = valid_s1 && !buf_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	upd_decode #(
		.MAX_STRING_LEN(MAX_STRING_LEN)
	) u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.grp     (grp)
	);

	upd_result_buf u_result_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv),
		.grp    (grp),
		.take   (take),
		.valid  (out_valid),
		.free   (buf_free),
		.head   (head)
	);

	assign out_kind   = head.kind;
	assign out_byte   = head.data;
	assign out_length = head.length;
	assign out_last   = head.last;

	// final result of a string is exactly the done or error result
	`UPD_ASSERT_IMPLIES(a_last_kind, clk, arst_n, out_valid, out_last == (head.kind != KIND_DATA))
	// unused fields come out as zero
	`UPD_ASSERT_IMPLIES(a_zero_fields, clk, arst_n, out_valid, ((head.kind != KIND_DATA) || (head.length == '0)) && ((head.kind == KIND_DATA) || (head.data == 8'h00)))
	// a full group only comes from a percent near the end and closes the string
	`UPD_ASSERT_NEXT(a_full_group, clk, arst_n, adv && (grp.n == 2'd3), out_valid && (head.data == CHAR_PCT) && (head.kind == KIND_DATA))

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench of the url percent decoder core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import upd_pkg::*;

	localparam int LEN_CAP = (MAX_STRING_LEN_DEF < LEN_FIELD_MAX) ?
		MAX_STRING_LEN_DEF : LEN_FIELD_MAX;
	localparam int RANDOM_PER_PHASE = 35;
	localparam int PRESSURE_BYTES = 40;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TIMEOUT_NS = 4_000_000;

	typedef struct packed {
		logic [7:0] b;
		logic       fin;
	} enc_byte_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       in_byte = 8'h00;
	logic             in_last = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       out_kind;
	logic [7:0]       out_byte;
	logic [LEN_W-1:0] out_length;
	logic             out_last;

	enc_byte_t pending_bytes[$];
	result_t   decoded_results[$];

	// decoder state as predicted from the accepted bytes
	mode_t            pct_state = MODE_NORMAL;
	logic [7:0]       first_digit = 8'h00;
	logic [LEN_W-1:0] decoded_len = '0;

	int   idle_pct = 0;
	int   stall_pct = 0;
	logic hold_off = 1'b0;

	int error_count = 0;
	int bytes_sent = 0;
	int strings_sent = 0;
	int results_seen = 0;
	int done_seen = 0;
	int capped_seen = 0;
	int bad_hex_seen = 0;
	int input_stall_cycles = 0;

	url_percent_decoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.out_length(out_length),
		.out_last(out_last)
	);

	always #4 clk = ~clk;

	initial begin
		#(TIMEOUT_NS);
		$display("timeout: %0d bytes still queued, %0d results outstanding",
			pending_bytes.size(), decoded_results.size());
		$display("testbench: errors");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 40) begin
			$display("mismatch at %0t ns: %s", $time, msg);
		end
	endtask

	function automatic logic is_hex_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		if (c <= "9") begin
			v = c - "0";
		end else if (c <= "F") begin
			v = c - "A" + 8'd10;
		end else begin
			v = c - "a" + 8'd10;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] space_for_plus(input logic [7:0] c);
		return (c == CHAR_PLUS) ? CHAR_SPACE : c;
	endfunction

	function automatic void push_data(input logic [7:0] c);
		result_t r;
		r.kind = KIND_DATA;
		r.data = c;
		r.length = '0;
		r.last = 1'b0;
		decoded_results.insert(decoded_results.size(), r);
		if (decoded_len < LEN_CAP) begin
			decoded_len++;
		end
	endfunction

	function automatic void push_done();
		result_t r;
		r.kind = KIND_DONE;
		r.data = 8'h00;
		r.length = decoded_len;
		r.last = 1'b1;
		decoded_results.insert(decoded_results.size(), r);
		decoded_len = '0;
		first_digit = 8'h00;
		pct_state = MODE_NORMAL;
	endfunction

	// expected results of one accepted byte
	function automatic void decode_byte(input logic [7:0] c, input logic fin);
		result_t r;
		case (pct_state)
			MODE_NORMAL: begin
				if (c == CHAR_PCT && !fin) begin
					pct_state = MODE_PCT;
				end else begin
					push_data(space_for_plus(c));
					if (fin) push_done();
				end
			end
			MODE_PCT: begin
				// string ends right after the percent: both go out literally
				if (fin) begin
					push_data(CHAR_PCT);
					push_data(space_for_plus(c));
					push_done();
				end else begin
					first_digit = c;
					pct_state = MODE_DIGIT;
				end
			end
			MODE_DIGIT: begin
				if (!is_hex_char(first_digit) || !is_hex_char(c)) begin
					r.kind = KIND_ERROR;
					r.data = 8'h00;
					r.length = '0;
					r.last = 1'b1;
					decoded_results.insert(decoded_results.size(), r);
					decoded_len = '0;
					first_digit = 8'h00;
					pct_state = fin ? MODE_NORMAL : MODE_DISCARD;
				end else begin
					push_data({hex_nibble(first_digit), hex_nibble(c)});
					first_digit = 8'h00;
					pct_state = MODE_NORMAL;
					if (fin) push_done();
				end
			end
			default: begin
				if (fin) begin
					pct_state = MODE_NORMAL;
					decoded_len = '0;
					first_digit = 8'h00;
				end
			end
		endcase
	endfunction

	task automatic add_byte(input logic [7:0] c, input logic fin);
		enc_byte_t e;
		e.b = c;
		e.fin = fin;
		pending_bytes.insert(pending_bytes.size(), e);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10) return "0" + n;
		return 8'(($urandom_range(1) ? "A" : "a") + n - 10);
	endfunction

	// escapes cut off by the end of the string give the percent-at-end cases
	task automatic add_string(input int n_bytes, input bit noisy);
		logic [7:0] text[$];
		int pick;
		while (text.size() < n_bytes) begin
			pick = $urandom_range(99);
			if (noisy || pick < 40) begin
				text.insert(text.size(), 8'($urandom_range(255)));
			end else if (pick < 55) begin
				text.insert(text.size(), CHAR_PLUS);
			end else if (pick < 90) begin
				text.insert(text.size(), CHAR_PCT);
				text.insert(text.size(), hex_char(4'($urandom)));
				text.insert(text.size(), hex_char(4'($urandom)));
			end else begin
				// broken escape, one digit from the whole byte range
				text.insert(text.size(), CHAR_PCT);
				if ($urandom_range(1)) begin
					text.insert(text.size(), 8'($urandom_range(255)));
					text.insert(text.size(), hex_char(4'($urandom)));
				end else begin
					text.insert(text.size(), hex_char(4'($urandom)));
					text.insert(text.size(), 8'($urandom_range(255)));
				end
			end
		end
		for (int i = 0; i < n_bytes; i++) begin
			add_byte(text[i], i == n_bytes - 1);
		end
	endtask

	task automatic add_random(input int count);
		int added;
		int n;
		added = 0;
		while (added < count) begin
			n = $urandom_range(1, 10);
			add_string(n, $urandom_range(99) < 20);
			added += n;
		end
	endtask

	task automatic run_phase(input int idle, input int stall, input int count);
		idle_pct = idle;
		stall_pct = stall;
		add_random(count);
		while (pending_bytes.size() != 0) @(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : byte_driver
		enc_byte_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			in_last <= 1'b0;
			pct_state = MODE_NORMAL;
			first_digit = 8'h00;
			decoded_len = '0;
		end else begin
			if (in_valid && in_stall) input_stall_cycles++;
			if (in_valid && !in_stall) begin
				decode_byte(in_byte, in_last);
				bytes_sent++;
				if (in_last) strings_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = pending_bytes.pop_front();
					in_valid <= 1'b1;
					in_byte <= nxt.b;
					in_last <= nxt.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_check
		result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (out_kind == KIND_DONE) begin
					done_seen++;
					if (out_length == LEN_CAP) capped_seen++;
				end
				if (out_kind == KIND_ERROR) bad_hex_seen++;
				if (decoded_results.size() == 0) begin
					report_mismatch($sformatf("unexpected kind %0d byte %02h length %0d last %0b",
						out_kind, out_byte, out_length, out_last));
				end else begin
					want = decoded_results.pop_front();
					if (out_kind !== want.kind || out_byte !== want.data ||
							out_length !== want.length || out_last !== want.last) begin
						report_mismatch($sformatf({"kind %0d/%0d byte %02h/%02h ",
							"length %0d/%0d last %0b/%0b (got/want)"},
							out_kind, want.kind, out_byte, want.data,
							out_length, want.length, out_last, want.last));
					end
				end
			end
			out_stall <= hold_off || ($urandom_range(99) < stall_pct);
		end
	end

	initial begin : stimulus
		int waited;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single bytes at both ends of the range, and a lone plus
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		add_byte(CHAR_PLUS, 1'b1);
		// percent on the final byte, then percent one before the end
		add_byte(CHAR_PCT, 1'b1);
		add_byte(CHAR_PCT, 1'b0);
		add_byte("4", 1'b1);
		add_byte(CHAR_PCT, 1'b0);
		add_byte(CHAR_PLUS, 1'b1);
		// good escapes in both letter cases
		add_byte(CHAR_PCT, 1'b0);
		add_byte("4", 1'b0);
		add_byte("a", 1'b1);
		add_byte(CHAR_PCT, 1'b0);
		add_byte("f", 1'b0);
		add_byte("F", 1'b1);
		add_byte(CHAR_PCT, 1'b0);
		add_byte("0", 1'b0);
		add_byte("0", 1'b1);
		// bad first digit mid-string, the tail gets dropped
		add_byte(CHAR_PCT, 1'b0);
		add_byte("g", 1'b0);
		add_byte("1", 1'b0);
		add_byte("x", 1'b0);
		add_byte("y", 1'b1);
		// bad second digit on the final byte
		add_byte(CHAR_PCT, 1'b0);
		add_byte("1", 1'b0);
		add_byte("z", 1'b1);

		run_phase(0, 0, RANDOM_PER_PHASE);
		run_phase(67, 0, RANDOM_PER_PHASE);
		run_phase(0, 67, RANDOM_PER_PHASE);
		run_phase(17, 17, RANDOM_PER_PHASE);

		// receiver holds off while the sender keeps offering
		idle_pct = 0;
		stall_pct = 0;
		add_random(PRESSURE_BYTES);
		fork
			begin
				hold_off = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end
		join_none
		while (pending_bytes.size() != 0) @(negedge clk);

		waited = 0;
		while ((pending_bytes.size() != 0 || in_valid || decoded_results.size() != 0) &&
				waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (decoded_results.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never came out",
				decoded_results.size()));
		end

		$display("run: %0d bytes in %0d strings, %0d results checked, input stalled %0d cycles",
			bytes_sent, strings_sent, results_seen, input_stall_cycles);
		$display("run: %0d strings done (%0d at the length cap), %0d bad-hex errors",
			done_seen, capped_seen, bad_hex_seen);
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
